// File: design/fps_pkg.sv
// fsk preamble search: shared widths, register indexes and reset values
// used by the top level and its port checker; no dependencies
`default_nettype none

package fps_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 21;
  localparam int THR_W       = 20;
  localparam int PAT_W       = 8;
  localparam int POS_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;

  localparam int BLK_SHIFT   = 4;
  localparam int BLOCK_LEN   = 16;
  localparam int SCAN_MARGIN = 256;
  localparam int PAT_LAST    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 20'd24000;
  localparam logic [PAT_W-1:0] PAT_RESET = 8'hA5;

endpackage

`default_nettype wire

// File: design/fsk_preamble_search_top.sv
// fsk preamble search top level: block sum accumulation, block sum memory
// and the scan sequencer with its shared compare unit; depends on fps_pkg
`default_nettype none

// Samples are taken one per cycle while in_stall is low and summed into
// aligned 16-sample blocks, each finished block sum going into an internal
// memory. The transfer that carries last starts a search and the input
// stalls until it ends. Each candidate offset takes a check step, then one
// memory read and one compare per block checked, up to eight blocks; up to
// (count-256)/16 offsets, rounded up, are tried before the result is handed
// over. Buffers of 256 samples or fewer skip the scan. The single read
// port and the shared threshold compare set this read-then-compare order.
// Configuration is written through cfg_valid/cfg_ready, which is always ready.
module fsk_preamble_search_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire signed [fps_pkg::SAMPLE_W-1:0] sample,
  input  wire                               last,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              found,
  output logic [fps_pkg::POS_W-1:0]         position,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [fps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [fps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_BLOCKS = MAX_SAMPLES / 16;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(NUM_BLOCKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                       state;
  logic [CW-1:0]                    count;
  logic signed [fps_pkg::SUM_W-1:0] acc;
  logic [CW-1:0]                    scan_end;
  logic [CW-1:0]                    offset;
  logic [2:0]                       bit_idx;
  logic                             res_found;
  logic [fps_pkg::THR_W-1:0]        thr;
  logic [fps_pkg::PAT_W-1:0]        pat;
  logic signed [fps_pkg::SUM_W-1:0] rd_data;
  logic signed [fps_pkg::SUM_W-1:0] mem [NUM_BLOCKS];

  logic                             accept;
  logic                             keep;
  logic                             blk_end;
  logic                             wr_ok;
  logic [CW-1:0]                    count_next;
  logic signed [fps_pkg::SUM_W-1:0] acc_sum;
  logic [AW-1:0]                    wr_addr;
  logic [AW-1:0]                    rd_addr;
  logic signed [fps_pkg::SUM_W:0]   rd_ext;
  logic signed [fps_pkg::SUM_W:0]   thr_ext;
  logic                             bit_ok;
  logic                             out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // block sum accumulation
  assign keep       = (count < CW'(MAX_SAMPLES));
  assign blk_end    = (count[fps_pkg::BLK_SHIFT-1:0] == {fps_pkg::BLK_SHIFT{1'b1}});
  assign wr_ok      = ((count >> fps_pkg::BLK_SHIFT) < CW'(NUM_BLOCKS));
  assign wr_addr    = AW'(count >> fps_pkg::BLK_SHIFT);
  assign count_next = keep ? count + 1'b1 : count;
  assign acc_sum    = acc + {{(fps_pkg::SUM_W - fps_pkg::SAMPLE_W){sample[fps_pkg::SAMPLE_W-1]}},
                             sample};

  // shared compare unit
  assign rd_addr = AW'(offset >> fps_pkg::BLK_SHIFT) + AW'({bit_idx, 1'b0});
  assign rd_ext  = {rd_data[fps_pkg::SUM_W-1], rd_data};
  assign thr_ext = $signed({2'b00, thr});
  assign bit_ok  = pat[bit_idx] ? (rd_ext <= -thr_ext) : (rd_ext >= thr_ext);

  always_ff @(posedge clk) begin
    if (accept && keep && blk_end && wr_ok) begin
      mem[wr_addr] <= acc_sum;
    end
    if (state == S_ISSUE) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= fps_pkg::THR_RESET;
      pat <= fps_pkg::PAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fps_pkg::REG_THRESHOLD: thr <= cfg_data;
        fps_pkg::REG_PATTERN:   pat <= cfg_data[fps_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (keep) begin
              acc <= blk_end ? '0 : acc_sum;
            end
            count <= count_next;
            if (last) begin
              count  <= '0;
              acc    <= '0;
              offset <= '0;
              if (count_next > CW'(fps_pkg::SCAN_MARGIN)) begin
                scan_end <= count_next - CW'(fps_pkg::SCAN_MARGIN);
                state    <= S_CHECK;
              end else begin
                res_found <= 1'b0;
                state     <= S_DONE;
              end
            end
          end
        end
        S_CHECK: begin
          if (offset < scan_end) begin
            bit_idx <= '0;
            state   <= S_ISSUE;
          end else begin
            res_found <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_ISSUE: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (bit_ok) begin
            if (bit_idx == 3'(fps_pkg::PAT_LAST)) begin
              res_found <= 1'b1;
              state     <= S_DONE;
            end else begin
              bit_idx <= bit_idx + 1'b1;
              state   <= S_ISSUE;
            end
          end else begin
            offset <= offset + CW'(fps_pkg::BLOCK_LEN);
            state  <= S_CHECK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= res_found;
            position  <= offset[fps_pkg::POS_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/fps_checker.sv
// fsk preamble search port checker and its bind to the top level
// watches only top-level ports; depends on fps_pkg
`default_nettype none

module fps_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire                        last,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire                        found,
  input wire [fps_pkg::POS_W-1:0]   position
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
    else $error("result changed while stalled");

  // offsets step by whole blocks
  a_pos_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position[fps_pkg::BLK_SHIFT-1:0] == '0)
    else $error("position not block aligned");

  // a last transfer starts the search and blocks input
  a_search_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input taken during search");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind fsk_preamble_search_top fps_checker u_fps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .position  (position)
);

`default_nettype wire
